// ===== src/cesc_pkg.sv =====
// Shared types, constants and decode functions for the C escape decoder.
package cesc_pkg;

	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [2:0] {
		PH_TEXT = 3'd0,
		PH_ESC  = 3'd1,
		PH_OCT  = 3'd2,
		PH_HEX  = 3'd3,
		PH_DROP = 3'd4
	} phase_t;

	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_DIGIT = 2'd1;
	localparam logic [1:0] ERR_RANGE = 2'd2;

	localparam logic [7:0] BACKSLASH = 8'h5C;
	localparam logic [7:0] CHAR_X    = 8'h78;

	// One queue word: pair means a backslash goes out ahead of data.
	typedef struct packed {
		logic       pair;
		logic [7:0] data;
		logic       last;
		logic [1:0] err;
	} entry_t;

	typedef struct packed {
		logic       hit;
		logic [7:0] code;
	} esc_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	function automatic esc_t single_escape(input logic [7:0] c);
		esc_t r;
		r.hit = 1'b1;
		case (c)
			8'h27: r.code = 8'h27;
			8'h22: r.code = 8'h22;
			8'h3F: r.code = 8'h3F;
			8'h5C: r.code = 8'h5C;
			8'h61: r.code = 8'h07;
			8'h62: r.code = 8'h08;
			8'h66: r.code = 8'h0C;
			8'h6E: r.code = 8'h0A;
			8'h72: r.code = 8'h0D;
			8'h74: r.code = 8'h09;
			8'h76: r.code = 8'h0B;
			default: begin
				r.hit  = 1'b0;
				r.code = 8'h00;
			end
		endcase
		return r;
	endfunction

	function automatic logic is_oct(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h37);
	endfunction

	function automatic hex_t hex_digit(input logic [7:0] c);
		hex_t r;
		r.ok  = 1'b1;
		r.val = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r.val = c[3:0];
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			r.val = c[3:0] + 4'd9;
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

endpackage

// ===== src/cesc_front.sv =====
// Front end: takes input bytes, tracks escape state, and pushes result words.
module cesc_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         in_byte,
	input  logic               in_last,
	output logic               push_valid,
	input  logic               push_ready,
	output cesc_pkg::entry_t   push_data
);

	cesc_pkg::phase_t phase_q, phase_d;
	logic [8:0]       value_q, value_d;
	logic [1:0]       count_q, count_d;

	cesc_pkg::esc_t   esc;
	cesc_pkg::hex_t   hx;
	logic             oct;
	logic [8:0]       oct_next;
	logic [8:0]       hex_next;
	logic [1:0]       cnt_inc;
	logic             emit;
	logic             fire;

	assign in_ready = push_ready;
	assign fire     = in_valid && push_ready;

	assign esc      = cesc_pkg::single_escape(in_byte);
	assign hx       = cesc_pkg::hex_digit(in_byte);
	assign oct      = cesc_pkg::is_oct(in_byte);
	assign oct_next = {value_q[5:0], in_byte[2:0]};
	assign hex_next = {value_q[4:0], hx.val};
	assign cnt_inc  = count_q + 2'd1;

	// next state
	always_comb begin
		phase_d = phase_q;
		value_d = value_q;
		count_d = count_q;
		case (phase_q)
			cesc_pkg::PH_ESC: begin
				phase_d = cesc_pkg::PH_TEXT;
				if (!esc.hit && oct && !in_last) begin
					phase_d = cesc_pkg::PH_OCT;
					value_d = {6'd0, in_byte[2:0]};
					count_d = 2'd1;
				end else if (!esc.hit && (oct || in_byte == cesc_pkg::CHAR_X)) begin
					// x, or a digit that ends the string
					phase_d = (in_byte == cesc_pkg::CHAR_X && !in_last) ?
						cesc_pkg::PH_HEX : cesc_pkg::PH_TEXT;
					value_d = '0;
					count_d = '0;
				end
			end
			cesc_pkg::PH_OCT: begin
				if (oct && cnt_inc < 2'd3 && !in_last) begin
					value_d = oct_next;
					count_d = cnt_inc;
				end else begin
					value_d = '0;
					count_d = '0;
					if (in_last || (oct && cnt_inc >= 2'd3 && !oct_next[8])) begin
						phase_d = cesc_pkg::PH_TEXT;
					end else begin
						phase_d = cesc_pkg::PH_DROP;
					end
				end
			end
			cesc_pkg::PH_HEX: begin
				if (hx.ok && cnt_inc < 2'd2 && !in_last) begin
					value_d = hex_next;
					count_d = cnt_inc;
				end else begin
					value_d = '0;
					count_d = '0;
					phase_d = (in_last || hx.ok) ? cesc_pkg::PH_TEXT : cesc_pkg::PH_DROP;
				end
			end
			cesc_pkg::PH_DROP: begin
				if (in_last) begin
					phase_d = cesc_pkg::PH_TEXT;
				end
			end
			default: begin
				phase_d = (in_byte == cesc_pkg::BACKSLASH && !in_last) ?
					cesc_pkg::PH_ESC : cesc_pkg::PH_TEXT;
			end
		endcase
	end

	// result word
	always_comb begin
		emit      = 1'b0;
		push_data = '{pair: 1'b0, data: in_byte, last: in_last, err: cesc_pkg::ERR_NONE};
		case (phase_q)
			cesc_pkg::PH_ESC: begin
				if (esc.hit) begin
					emit           = 1'b1;
					push_data.data = esc.code;
				end else if (oct || in_byte == cesc_pkg::CHAR_X) begin
					if (in_last) begin
						emit      = 1'b1;
						push_data = '{pair: 1'b0, data: 8'd0, last: 1'b1,
							err: cesc_pkg::ERR_DIGIT};
					end
				end else begin
					emit           = 1'b1;
					push_data.pair = 1'b1;
				end
			end
			cesc_pkg::PH_OCT: begin
				if (!oct || (cnt_inc < 2'd3 && in_last)) begin
					emit      = 1'b1;
					push_data = '{pair: 1'b0, data: 8'd0, last: 1'b1,
						err: cesc_pkg::ERR_DIGIT};
				end else if (cnt_inc >= 2'd3) begin
					emit = 1'b1;
					if (oct_next[8]) begin
						push_data = '{pair: 1'b0, data: 8'd0, last: 1'b1,
							err: cesc_pkg::ERR_RANGE};
					end else begin
						push_data.data = oct_next[7:0];
					end
				end
			end
			cesc_pkg::PH_HEX: begin
				if (!hx.ok || (cnt_inc < 2'd2 && in_last)) begin
					emit      = 1'b1;
					push_data = '{pair: 1'b0, data: 8'd0, last: 1'b1,
						err: cesc_pkg::ERR_DIGIT};
				end else if (cnt_inc >= 2'd2) begin
					emit           = 1'b1;
					push_data.data = hex_next[7:0];
				end
			end
			cesc_pkg::PH_DROP: begin
				emit = 1'b0;
			end
			default: begin
				emit = !(in_byte == cesc_pkg::BACKSLASH && !in_last);
			end
		endcase
	end

	assign push_valid = in_valid && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= cesc_pkg::PH_TEXT;
			value_q <= '0;
			count_q <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			value_q <= value_d;
			count_q <= count_d;
		end
	end

endmodule

// ===== src/cesc_queue.sv =====
// Small FIFO of result words between front and back.
module cesc_queue #(
	parameter int Depth = cesc_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  cesc_pkg::entry_t push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output cesc_pkg::entry_t pop_data
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	cesc_pkg::entry_t mem_q [Depth];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = count_q != CntW'(Depth);
	assign pop_valid  = count_q != '0;
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CntW'(1);
				2'b01:   count_q <= count_q - CntW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== src/cesc_back.sv =====
// Back end: expands queue words into results and holds the output register.
module cesc_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pop_valid,
	output logic             pop_ready,
	input  cesc_pkg::entry_t pop_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       out_byte,
	output logic             out_last,
	output logic [1:0]       error_kind
);

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;
	logic [1:0] error_kind_q;
	logic       second_q;
	logic       load;
	logic       lead;

	assign load      = !out_valid_q || out_ready;
	// lead: first half of a pair, the backslash
	assign lead      = pop_data.pair && !second_q;
	assign pop_ready = load && !lead;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			second_q    <= 1'b0;
		end else if (load) begin
			out_valid_q <= pop_valid;
			if (pop_valid) begin
				second_q <= lead;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && pop_valid) begin
			out_byte_q   <= lead ? cesc_pkg::BACKSLASH : pop_data.data;
			out_last_q   <= pop_data.last && !lead;
			error_kind_q <= pop_data.err;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign out_last   = out_last_q;
	assign error_kind = error_kind_q;

endmodule

// ===== src/c_escape_decoder.sv =====
// Top level of the C escape decoder: front end, result queue and back end.
// Decodes C character escapes in a byte string that arrives one byte per word
// with a last mark on the final byte. Plain bytes pass through; a backslash and
// one of ' " ? \ a b f n r t v give one control byte; a backslash and three
// octal digits give their value (above 255 is error 2); a backslash, x and two
// hex digits give their value; a backslash and any other byte give both bytes.
// A missing or bad digit gives error 1. An error shows as one result with a
// zero byte, marked last, and the rest of that string is dropped.
// The front end takes one byte per clock, stalled only when the result queue is
// full, and advances its escape state on each byte. The output gives one result
// per clock while out_ready is high, so a pass-through escape (two results from
// two bytes) keeps the pace; the back end gives a backslash pair as two results.
// A result is registered in the queue, then in the output register. Queue depth
// is set by QueueDepth (at least 2).
module c_escape_decoder #(
	parameter int QueueDepth = cesc_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       out_last,
	output logic [1:0] error_kind
);

	// front -> queue
	logic             push_valid;
	logic             push_ready;
	cesc_pkg::entry_t push_data;

	// queue -> back
	logic             pop_valid;
	logic             pop_ready;
	cesc_pkg::entry_t pop_data;

	cesc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.in_last    (in_last),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	cesc_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// Back end owns the output register; out_ready reaches the queue's pop_ready combinationally.
	cesc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.out_last   (out_last),
		.error_kind (error_kind)
	);

endmodule

// ===== src/cesc_checker.sv =====
// Port-level checks for the C escape decoder, bound to the top level.
module cesc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       out_last,
	input logic [1:0] error_kind
);

	// error word carries a zero byte and closes the string
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_kind != cesc_pkg::ERR_NONE |-> out_byte == 8'd0 && out_last)
		else $error("error word not zero or not last");

	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> error_kind == cesc_pkg::ERR_NONE || error_kind == cesc_pkg::ERR_DIGIT
			|| error_kind == cesc_pkg::ERR_RANGE)
		else $error("unknown error code");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last)
			&& $stable(error_kind))
		else $error("stalled output word changed");

endmodule

bind c_escape_decoder cesc_checker u_cesc_checker (.*);
